// File: src/gsa_pkg.sv
package gsa_pkg;

  localparam int SLOTS = 128;
  localparam int VERSION_BITS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_CHECK   = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_BEGIN   = 3'd4,
    CMD_FINISH  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [VERSION_BITS-1:0] version;
    logic                    canceled;
    logic [1:0]              phase;
  } slot_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        index;
    logic [VERSION_BITS-1:0] version;
    logic                    canceled;
    logic [1:0]              phase;
  } res_t;

  // Free stack request from the command stage
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } stk_op_t;

  // Free stack state, current and after the request
  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] depth_next;
    logic [IDX_W-1:0] top_next;
  } stk_view_t;

endpackage

// File: src/gsa_req_if.sv
interface gsa_req_if;
  import gsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [2:0]              command;
  logic [IDX_W-1:0]        slot_index;
  logic [VERSION_BITS-1:0] handle_version;

  modport source (output valid, output command, output slot_index,
                  output handle_version, input ready);
  modport sink (input valid, input command, input slot_index,
                input handle_version, output ready);
endinterface

// File: src/gsa_rsp_if.sv
interface gsa_rsp_if;
  import gsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [IDX_W-1:0]        given_index;
  logic [VERSION_BITS-1:0] given_version;
  logic                    cancel_mark;
  logic [1:0]              run_phase;

  modport source (output valid, output status, output given_index,
                  output given_version, output cancel_mark, output run_phase,
                  input ready);
  modport sink (input valid, input status, input given_index,
                input given_version, input cancel_mark, input run_phase,
                output ready);
endinterface

// File: src/gsa_ram.sv
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/gsa_free_stack.sv
module gsa_free_stack (
  input  logic              clk,
  input  logic              rst,
  input  gsa_pkg::stk_op_t  op,
  output gsa_pkg::stk_view_t view
);
  import gsa_pkg::*;

  // Top entry lives in a register; entries below it live in the RAM.
  logic [CNT_W-1:0] depth;
  logic [IDX_W-1:0] top;
  logic [CNT_W-1:0] depth_next;
  logic [IDX_W-1:0] top_next;
  logic             push_ok;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] rdata;
  logic [IDX_W-1:0] below;
  logic             byp_valid;
  logic [IDX_W-1:0] byp_data;

  assign below = byp_valid ? byp_data : rdata;

  always_comb begin
    push_ok    = op.push && (depth < CNT_W'(SLOTS));
    we         = push_ok && (depth != '0);
    waddr      = IDX_W'(depth - CNT_W'(1));
    depth_next = depth;
    top_next   = top;
    priority if (push_ok) begin
      depth_next = depth + CNT_W'(1);
      top_next   = op.push_idx;
    end else if (op.pop) begin
      depth_next = depth - CNT_W'(1);
      top_next   = below;
    end else begin
      depth_next = depth;
      top_next   = top;
    end
    // Prefetch the entry just below the coming top
    raddr = IDX_W'(depth_next - CNT_W'(2));
  end

  gsa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(top),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      byp_valid <= 1'b0;
    end else begin
      depth     <= depth_next;
      byp_valid <= we;
    end
    top      <= top_next;
    byp_data <= top;
  end

  assign view = '{depth: depth, depth_next: depth_next, top_next: top_next};

endmodule

// File: src/generational_slot_allocator.sv
// Channel  Dir  Fields                                        Accepted when
// req      in   command, slot_index, handle_version           req.valid && req.ready
// rsp      out  status, given_index, given_version,           rsp.valid && rsp.ready
//               cancel_mark, run_phase
//
// Takes one item per cycle unless rsp stalls; its result is registered on fire.
// The item sits in the command stage while the slot table RAM read lands,
// then slot table, free stack and counters update as the result registers.
// No clearing pass after reset: a slot is written when first handed out.
// A stalled rsp holds the command stage; req stays ready while it is empty.
module generational_slot_allocator (
  input logic      clk,
  input logic      rst,
  gsa_req_if.sink   req,
  gsa_rsp_if.source rsp
);
  import gsa_pkg::*;

  // Command stage
  logic                    s1_valid;
  logic [2:0]              s1_cmd;
  logic [IDX_W-1:0]        s1_idx;
  logic [VERSION_BITS-1:0] s1_ver;
  logic [IDX_W-1:0]        s1_addr;
  logic                    fire;
  logic                    accept;

  // Slot table and its one-deep write bypass
  logic             tab_we;
  logic [IDX_W-1:0] tab_raddr;
  slot_t            tab_wdata;
  slot_t            tab_rdata;
  slot_t            tab_byp;
  logic             tab_hit;
  slot_t            rd;
  slot_t            entry;

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] used_next;
  logic             handle_ok;

  stk_op_t   stk_op;
  stk_view_t stk;

  res_t res;
  res_t res_next;
  logic rsp_valid;

  assign fire       = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready  = !s1_valid || fire;
  assign accept     = req.valid && req.ready;

  assign rd        = tab_hit ? tab_byp : tab_rdata;
  assign handle_ok = (CNT_W'(s1_idx) < used) && (rd.version == s1_ver);

  // Work out the item in the command stage; commit only on fire.
  always_comb begin
    entry     = rd;
    res_next  = '0;
    used_next = used;
    stk_op    = '0;
    tab_we    = 1'b0;
    unique case (s1_cmd)
      CMD_ALLOC: begin
        priority if (stk.depth != '0) begin
          // Reuse the last freed slot, keep its version
          stk_op.pop     = 1'b1;
          entry.canceled = 1'b0;
          entry.phase    = PH_IDLE;
          tab_we         = 1'b1;
        end else if (used < CNT_W'(SLOTS)) begin
          // Fresh slot starts at version zero
          used_next = used + CNT_W'(1);
          entry     = '0;
          tab_we    = 1'b1;
        end else begin
          // Table full: hand out nothing
          tab_we = 1'b0;
        end
        if (tab_we) begin
          res_next = '{status: ST_OK, index: s1_addr, version: entry.version,
                       canceled: entry.canceled, phase: entry.phase};
        end else begin
          res_next.status = ST_FULL;
        end
      end
      CMD_RELEASE, CMD_CHECK, CMD_CANCEL, CMD_BEGIN, CMD_FINISH: begin
        if (handle_ok) begin
          unique case (s1_cmd)
            CMD_RELEASE: begin
              entry.version   = rd.version + VERSION_BITS'(1);
              stk_op.push     = 1'b1;
              stk_op.push_idx = s1_idx;
            end
            CMD_CANCEL: entry.canceled = 1'b1;
            CMD_BEGIN:  entry.phase    = PH_RUN;
            CMD_FINISH: entry.phase    = PH_DONE;
            default:    entry          = rd;
          endcase
          tab_we   = 1'b1;
          res_next = '{status: ST_OK, index: s1_idx, version: entry.version,
                       canceled: entry.canceled, phase: entry.phase};
        end else begin
          res_next.status = ST_STALE;
          res_next.index  = s1_idx;
        end
      end
      default: begin
        // Unknown command: reject like a stale handle
        res_next.status = ST_STALE;
        res_next.index  = s1_idx;
      end
    endcase
    if (!fire) begin
      tab_we    = 1'b0;
      stk_op    = '0;
      used_next = used;
    end
    tab_wdata = entry;
  end

  // Slot to read for the next item: allocate looks ahead at the free stack
  // and fill count as they stand after the item now committing.
  always_comb begin
    if (accept) begin
      if (req.command == CMD_ALLOC) begin
        tab_raddr = (stk.depth_next != '0) ? stk.top_next : IDX_W'(used_next);
      end else begin
        tab_raddr = req.slot_index;
      end
    end else begin
      tab_raddr = s1_addr;
    end
  end

  gsa_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slot_table (
    .clk  (clk),
    .we   (tab_we),
    .waddr(s1_addr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  gsa_free_stack u_free_stack (
    .clk (clk),
    .rst (rst),
    .op  (stk_op),
    .view(stk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      used      <= '0;
      tab_hit   <= 1'b0;
    end else begin
      used    <= used_next;
      tab_hit <= tab_we && (s1_addr == tab_raddr);
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    tab_byp <= tab_wdata;
    // Hold the item while stalled; the read address holds with it
    if (accept) begin
      s1_cmd <= req.command;
      s1_idx <= req.slot_index;
      s1_ver <= req.handle_version;
    end
    s1_addr <= tab_raddr;
    if (fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = res.status;
  assign rsp.given_index   = res.index;
  assign rsp.given_version = res.version;
  assign rsp.cancel_mark   = res.canceled;
  assign rsp.run_phase     = res.phase;

endmodule
